/* rtl/core/six_channel_moving_average_unit_assert.svh */
// Assertion macros shared by the checker of the six-channel moving average unit.
`ifndef SIX_CHANNEL_MOVING_AVERAGE_UNIT_ASSERT_SVH
`define SIX_CHANNEL_MOVING_AVERAGE_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define SMAU_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SMAU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/smau_pkg.sv */
// Types and constants shared by the six-channel moving average unit.
`timescale 1ns / 1ps

package smau_pkg;

   localparam int NUM_CH      = 6;
   localparam int CH_W        = $clog2(NUM_CH);
   localparam int SAMPLE_BITS = 32;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef struct packed {
      sample_type pos_x;
      sample_type pos_y;
      sample_type pos_z;
      sample_type vel_x;
      sample_type vel_y;
      sample_type vel_z;
   } req_type;

   typedef struct packed {
      sample_type avg_pos_x;
      sample_type avg_pos_y;
      sample_type avg_pos_z;
      sample_type avg_vel_x;
      sample_type avg_vel_y;
      sample_type avg_vel_z;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic            capture;
      logic            rd;
      logic            upd;
      logic            adv;
      logic            div_load;
      logic            div_step;
      logic            div_store;
      logic            publish;
      logic [CH_W-1:0] chan;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
   } sts_type;

endpackage

/* rtl/core/smau_dpath.sv */
// Datapath: sample ring, running sums, shared serial divider and output register.
`timescale 1ns / 1ps

module smau_dpath #(
   parameter int WINDOW = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  smau_pkg::req_type req,
   input  smau_pkg::cmd_type cmd,
   input  logic              rsp_stall,
   output smau_pkg::sts_type sts,
   output logic              rsp_valid,
   output smau_pkg::rsp_type rsp
);
   import smau_pkg::*;

   localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW);
   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int DEPTH  = WINDOW * NUM_CH;
   localparam int ADDR_W = $clog2(DEPTH);

   req_type                   item_ff;
   sample_type                new_samp [NUM_CH];
   sample_type                ring_ff  [DEPTH];
   sample_type                old_ff;
   logic signed [SUM_W-1:0]   sum_ff   [NUM_CH];
   logic signed [SUM_W-1:0]   sum_cur;
   logic signed [SUM_W-1:0]   sum_upd;
   logic signed [SUM_W-1:0]   old_ext;
   logic [CNT_W-1:0]          fill_ff, fill_in;
   logic [SLOT_W-1:0]         slot_ff, slot_in;
   logic                      full;
   logic [ADDR_W-1:0]         addr;
   logic [SUM_W-1:0]          dvd_ff, dvd_in;
   logic [CNT_W-1:0]          rem_ff, rem_in;
   logic                      neg_ff;
   logic [CNT_W:0]            rem_sh;
   logic [CNT_W:0]            diff;
   logic                      ge;
   logic [SUM_W-1:0]          quot;
   sample_type                res_ff   [NUM_CH];
   rsp_type                   out_ff;
   logic                      out_valid_ff, out_valid_in;

   assign new_samp[0] = item_ff.pos_x;
   assign new_samp[1] = item_ff.pos_y;
   assign new_samp[2] = item_ff.pos_z;
   assign new_samp[3] = item_ff.vel_x;
   assign new_samp[4] = item_ff.vel_y;
   assign new_samp[5] = item_ff.vel_z;

   assign full = (fill_ff == CNT_W'(WINDOW));
   assign addr = ADDR_W'(slot_ff) * ADDR_W'(NUM_CH) + ADDR_W'(cmd.chan);

   // Once the window is full the oldest sample leaves the sum.
   assign sum_cur = sum_ff[cmd.chan];
   assign old_ext = full ? SUM_W'(old_ff) : '0;
   assign sum_upd = sum_cur - old_ext + SUM_W'(new_samp[cmd.chan]);

   always_comb begin
      fill_in = fill_ff;
      slot_in = slot_ff;
      if (cmd.adv) begin
         if (!full) begin
            fill_in = fill_ff + CNT_W'(1);
         end
         if (slot_ff == SLOT_W'(WINDOW - 1)) begin
            slot_in = '0;
         end else begin
            slot_in = slot_ff + SLOT_W'(1);
         end
      end
   end

   // Restoring division of the sum magnitude, one quotient bit per cycle.
   assign rem_sh = {rem_ff, dvd_ff[SUM_W-1]};
   assign diff   = rem_sh - {1'b0, fill_ff};
   assign ge     = ~diff[CNT_W];

   always_comb begin
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      if (cmd.div_load) begin
         dvd_in = sum_cur[SUM_W-1] ? -sum_cur : sum_cur;
         rem_in = '0;
      end else if (cmd.div_step) begin
         dvd_in = {dvd_ff[SUM_W-2:0], ge};
         rem_in = ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      end
   end

   assign quot = neg_ff ? -dvd_ff : dvd_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.publish) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CH; c++) begin
            sum_ff[c] <= '0;
         end
         fill_ff      <= '0;
         slot_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.upd) begin
            sum_ff[cmd.chan] <= sum_upd;
         end
         fill_ff      <= fill_in;
         slot_ff      <= slot_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Sample ring, one port, read or written per cycle.
   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         old_ff <= ring_ff[addr];
      end
      if (cmd.upd) begin
         ring_ff[addr] <= new_samp[cmd.chan];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      if (cmd.div_load) begin
         neg_ff <= sum_cur[SUM_W-1];
      end
      if (cmd.div_store) begin
         res_ff[cmd.chan] <= quot[SAMPLE_BITS-1:0];
      end
      if (cmd.publish) begin
         out_ff.avg_pos_x <= res_ff[0];
         out_ff.avg_pos_y <= res_ff[1];
         out_ff.avg_pos_z <= res_ff[2];
         out_ff.avg_vel_x <= res_ff[3];
         out_ff.avg_vel_y <= res_ff[4];
         out_ff.avg_vel_z <= res_ff[5];
      end
   end

   assign sts.out_free = ~out_valid_ff | ~rsp_stall;
   assign rsp_valid    = out_valid_ff;
   assign rsp          = out_ff;

endmodule

/* rtl/core/smau_ctrl.sv */
// Controller: sequences ring update, per-channel division and result hand-off.
`timescale 1ns / 1ps

module smau_ctrl #(
   parameter int SUM_W = 36
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  smau_pkg::sts_type sts,
   output logic              req_stall,
   output smau_pkg::cmd_type cmd
);
   import smau_pkg::*;

   localparam int STEP_W = $clog2(SUM_W);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_RD     = 3'd1;
   localparam logic [2:0] S_UPD    = 3'd2;
   localparam logic [2:0] S_ADV    = 3'd3;
   localparam logic [2:0] S_DLOAD  = 3'd4;
   localparam logic [2:0] S_DSTEP  = 3'd5;
   localparam logic [2:0] S_DSTORE = 3'd6;
   localparam logic [2:0] S_PUB    = 3'd7;

   logic [2:0]        state_ff, state_in;
   logic [CH_W-1:0]   chan_ff, chan_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              last_chan;

   assign last_chan = (chan_ff == CH_W'(NUM_CH - 1));
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      chan_in  = chan_ff;
      step_in  = step_ff;
      cmd      = '0;
      cmd.chan = chan_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               chan_in     = '0;
               state_in    = S_RD;
            end
         end
         S_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_UPD;
         end
         S_UPD: begin
            cmd.upd = 1'b1;
            if (last_chan) begin
               chan_in  = '0;
               state_in = S_ADV;
            end else begin
               chan_in  = chan_ff + CH_W'(1);
               state_in = S_RD;
            end
         end
         S_ADV: begin
            cmd.adv  = 1'b1;
            state_in = S_DLOAD;
         end
         S_DLOAD: begin
            cmd.div_load = 1'b1;
            step_in      = '0;
            state_in     = S_DSTEP;
         end
         S_DSTEP: begin
            cmd.div_step = 1'b1;
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               state_in = S_DSTORE;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         S_DSTORE: begin
            cmd.div_store = 1'b1;
            if (last_chan) begin
               chan_in  = '0;
               state_in = S_PUB;
            end else begin
               chan_in  = chan_ff + CH_W'(1);
               state_in = S_DLOAD;
            end
         end
         S_PUB: begin
            if (sts.out_free) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         chan_ff  <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         chan_ff  <= chan_in;
         step_ff  <= step_in;
      end
   end

endmodule

/* rtl/core/six_channel_moving_average_unit.sv */
// Top level of the six-channel boxcar moving average unit.
`timescale 1ns / 1ps

// Six-channel boxcar moving average. Each transfer on the req_ channel carries
// six signed Q16.16 samples (position x, y, z and velocity x, y, z); for each
// one the unit returns one rsp_ transfer with the six means over the newest
// WINDOW samples, or over all samples seen so far while the window is still
// filling. Means truncate toward zero. The unit works on one item at a time:
// an item is taken only after the previous one has gone through the ring
// update of each channel, the six divisions and publishing. SUM_W = 32 +
// clog2(WINDOW) is the width of the running sums. The time per item is set
// by the single shared restoring divider, which produces one quotient bit
// per cycle and serves the six channels in turn, and by the single port of
// the sample ring, which is read and written once per channel. A finished
// result sits in an output register, so the next item is taken while the
// result still waits under rsp_stall; it only holds off publishing the
// following result. There is no clearing pass after reset: a ring entry's
// value is used in a sum only once it has been written.

module six_channel_moving_average_unit #(
   parameter int WINDOW = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  smau_pkg::req_type req,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output smau_pkg::rsp_type rsp
);
   import smau_pkg::*;

   // Wide enough to hold the sum of WINDOW full-scale samples.
   localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW);

   cmd_type cmd;
   sts_type sts;

   // Sequencer: one transfer in, ring update per channel, six divisions, publish.
   smau_ctrl #(
      .SUM_W (SUM_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .sts       (sts),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   // Storage and arithmetic: ring, sums, fill count, divider, result register.
   smau_dpath #(
      .WINDOW (WINDOW)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .cmd       (cmd),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

endmodule

/* rtl/core/smau_checker.sv */
// Port-level checker for the six-channel moving average unit, with its bind.
`timescale 1ns / 1ps
`include "six_channel_moving_average_unit_assert.svh"

module smau_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input smau_pkg::req_type req,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input smau_pkg::rsp_type rsp
);

   // A result waiting under stall must stay put.
   `SMAU_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "rsp moved")

   // Items are processed one at a time, so an accepted transfer closes the input.
   `SMAU_ASSERT_NEXT(a_one_at_a_time, req_valid && !req_stall, req_stall, "input not closed")

   // A result needs the ring update and the divisions first; none can appear right after a transfer.
   `SMAU_ASSERT_NEXT(a_no_instant_rsp, req_valid && !req_stall, !$rose(rsp_valid), "early result")

   // Right out of reset the unit is empty and ready.
   `SMAU_ASSERT_SAME(a_reset_state, $past(reset), !rsp_valid && !req_stall, "not idle")

endmodule

bind six_channel_moving_average_unit smau_checker u_checker (.*);

/* verif/testbench.sv */
// Self-checking testbench for the six-channel boxcar moving average unit.
`timescale 1ns / 1ps

module testbench;

   import smau_pkg::*;

   // The window length under test; the unit is built with the same value.
   localparam int WINDOW       = 16;
   localparam int TABLE_ROWS   = 25;
   localparam int RANDOM_ITEMS = 1400;
   localparam int TOTAL_ITEMS  = TABLE_ROWS + RANDOM_ITEMS;
   // This outlasts the time the unit needs for one item.
   localparam int DRAIN_CYCLES = 300;
   localparam int HOLD_CYCLES  = 2000;
   localparam int HOLD_AT_ITEM = 250;
   localparam int QUIET_ITEMS  = 150;

   localparam sample_type S_MAX = 32'sh7FFF_FFFF;
   localparam sample_type S_MIN = 32'sh8000_0000;
   localparam sample_type S_ONE = 32'sh0001_0000;

   // One row of the directed table. Where a row's result can be read off
   // at a glance, known_mean holds it and is checked instead of the
   // predicted mean.
   typedef struct {
      req_type item;
      bit      has_known;
      rsp_type known_mean;
   } table_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp;

   // Predictor state: the ring of held samples, one running sum per
   // channel, the number of samples held and the slot the next one goes to.
   longint window_ring [WINDOW][NUM_CH];
   longint window_sums [NUM_CH];
   int     held_count = 0;
   int     next_slot = 0;

   // Means that the unit still owes, oldest first: entries from owed_rd up
   // to owed_wr are outstanding.
   rsp_type owed_means [TOTAL_ITEMS];
   int      owed_wr = 0;
   int      owed_rd = 0;

   table_row_type stimulus_table [TABLE_ROWS];
   int  error_count = 0;
   bit  quiet_tail = 1'b0;
   bit  hold_off_pending = 1'b0;
   int  gap_odds = 0;
   string channel_names [NUM_CH] = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y", "vel_z"};

   six_channel_moving_average_unit #(
      .WINDOW(WINDOW)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req      (req),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp      (rsp)
   );

   always #5 clock = ~clock;

   // Picks channel c out of a packed item; pos_x sits in the top bits.
   function automatic sample_type lane(input logic [NUM_CH*SAMPLE_BITS-1:0] bits,
                                       input int c);
      return bits[(NUM_CH-1-c)*SAMPLE_BITS +: SAMPLE_BITS];
   endfunction

   // Takes one accepted item into the predicted window and returns the six
   // means. While the window fills, nothing leaves the sums and the divisor is the
   // number of samples held. Once it is full, the oldest sample sits in the
   // slot being written and leaves the sum before the new one arrives.
   // Signed division of the sums truncates toward zero, as the unit does.
   function automatic rsp_type advance_window(input req_type item);
      rsp_type mean;
      longint  sample;
      longint  quotient;
      bit      full;
      full = (held_count >= WINDOW);
      for (int c = 0; c < NUM_CH; c++) begin
         sample = longint'(lane(item, c));
         if (full) begin
            window_sums[c] -= window_ring[next_slot][c];
         end
         window_ring[next_slot][c] = sample;
         window_sums[c] += sample;
      end
      if (!full) begin
         held_count++;
      end
      next_slot = (next_slot + 1) % WINDOW;
      for (int c = 0; c < NUM_CH; c++) begin
         quotient = window_sums[c] / held_count;
         mean[(NUM_CH-1-c)*SAMPLE_BITS +: SAMPLE_BITS] = quotient[SAMPLE_BITS-1:0];
      end
      return mean;
   endfunction

   // Offers one item on the request channel and returns at the rising edge
   // where it is taken. The call starts at the edge of the previous transfer,
   // so valid stays high across back-to-back transfers and only drops for a
   // gap; it is never lowered and raised within one time step.
   task automatic send_sample(input req_type item, input bit has_known,
                              input rsp_type known_mean);
      rsp_type predicted;
      @(negedge clock);
      if (!quiet_tail && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req       <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      predicted = advance_window(item);
      owed_means[owed_wr] = has_known ? known_mean : predicted;
      owed_wr++;
   endtask

   // Random samples. Style 0 keeps content random; the streak styles pin
   // channels at the extremes so the sums reach the far ends of their range,
   // and small values bring out truncation of negative means.
   function automatic req_type random_sample(input int style);
      req_type    item;
      sample_type value;
      for (int c = 0; c < NUM_CH; c++) begin
         case ($urandom_range(0, 3))
            0: value = $urandom;
            1: value = $urandom_range(0, 200) - 100;
            2: value = ($urandom_range(0, 1) ? S_MAX : S_MIN) - $urandom_range(0, 1);
            default: value = $signed($urandom_range(0, 200 * S_ONE)) - 100 * S_ONE;
         endcase
         if (style == 1 && $urandom_range(0, 7) != 0) begin
            value = S_MAX;
         end else if (style == 2 && $urandom_range(0, 7) != 0) begin
            value = S_MIN;
         end
         item[(NUM_CH-1-c)*SAMPLE_BITS +: SAMPLE_BITS] = value;
      end
      return item;
   endfunction

   // Request side: reset, the directed table, then random items in segments
   // that vary the style of content and how often the sender idles.
   initial begin : request_driver
      int style;
      for (int r = 0; r < TABLE_ROWS; r++) begin
         stimulus_table[r].has_known  = 1'b0;
         stimulus_table[r].known_mean = '0;
      end
      // The first item after reset is its own mean, extremes included.
      stimulus_table[0].item       = '{S_MAX, S_MIN, 32'sd0, -32'sd1, 32'sd1, S_ONE};
      stimulus_table[0].has_known  = 1'b1;
      stimulus_table[0].known_mean = stimulus_table[0].item;
      // Sums over two samples, some odd and negative: the means truncate toward zero.
      stimulus_table[1].item = '{S_MAX, S_MIN, -32'sd3, -32'sd2, 32'sd2, -32'sh0000_8000};
      // Sixteen full-scale items push the first two out of the window, so the
      // last of them must average to full scale on every channel.
      for (int r = 2; r < 18; r++) begin
         stimulus_table[r].item = '{default: S_MAX};
      end
      stimulus_table[17].has_known  = 1'b1;
      stimulus_table[17].known_mean = '{default: S_MAX};
      // The window full with the opposite extreme coming in.
      for (int r = 18; r < 23; r++) begin
         stimulus_table[r].item = '{default: S_MIN};
      end
      stimulus_table[23].item = '{default: 32'sh5555_5555};
      stimulus_table[24].item = '{default: 32'shAAAA_AAAA};

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < TABLE_ROWS; r++) begin
         send_sample(stimulus_table[r].item, stimulus_table[r].has_known,
                     stimulus_table[r].known_mean);
      end

      style = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) begin
            gap_odds = (n / 100) % 3 == 0 ? 0 : ((n / 100) % 3 == 1 ? 6 : 2);
         end
         if (n % 50 == 0) begin
            style = $urandom_range(0, 4) < 3 ? 0 : $urandom_range(1, 2);
         end
         if (n == HOLD_AT_ITEM) begin
            hold_off_pending = 1'b1;
         end
         if (n == RANDOM_ITEMS - QUIET_ITEMS) begin
            quiet_tail = 1'b1;
         end
         send_sample(random_sample(style), 1'b0, '0);
      end
      @(negedge clock);
      req_valid <= 1'b0;

      // Wait for every owed mean, then give a stray result time to show up.
      while (owed_rd != owed_wr) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Result side: stall bursts whose frequency changes from mode to mode,
   // including stretches with none. Once, the receiver holds off long enough
   // that the output register and the unit both fill and req_stall rises.
   initial begin : result_receiver
      int mode_left;
      int stall_odds;
      int hold_count;
      mode_left  = 0;
      stall_odds = 0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (mode_left <= 0) begin
            mode_left  = 1000;
            stall_odds = $urandom_range(0, 2) == 0 ? 0 : ($urandom_range(0, 1) ? 3 : 12);
         end
         mode_left--;
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_stall <= 1'b1;
            for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) begin
               @(negedge clock);
            end
            rsp_stall <= 1'b0;
         end else if (!quiet_tail && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Every result transfer is matched against the oldest owed mean.
   always @(posedge clock) begin : result_checker
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (owed_rd == owed_wr) begin
            $display("%0t: result with no mean owed, expected none, actual %h", $time, rsp);
            error_count++;
         end else begin
            want = owed_means[owed_rd];
            owed_rd++;
            for (int c = 0; c < NUM_CH; c++) begin
               if (lane(rsp, c) !== lane(want, c)) begin
                  $display("%0t: avg_%s mismatch, expected %0d, actual %0d", $time,
                           channel_names[c], lane(want, c), lane(rsp, c));
                  error_count++;
               end
            end
         end
      end
   end

   // Ends a run that never finishes, as a failure.
   initial begin : run_limit
      #20_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/smau_pkg.sv
rtl/core/smau_dpath.sv
rtl/core/smau_ctrl.sv
rtl/core/six_channel_moving_average_unit.sv
rtl/core/smau_checker.sv
verif/testbench.sv
